/* hw/rtl/hershey_stroke_transform_assert.svh */
// Assertion macros shared by the stroke transform checker
`ifndef HERSHEY_STROKE_TRANSFORM_ASSERT_SVH
`define HERSHEY_STROKE_TRANSFORM_ASSERT_SVH

// same-cycle implication, masked during reset
`define HST_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stroke transform check failed");

// next-cycle implication, masked during reset
`define HST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stroke transform check failed");

// next-cycle implication, active through reset
`define HST_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stroke transform check failed");

`endif

/* hw/rtl/hst_pkg.sv */
// Package: shared types and constants of the stroke transform
package hst_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_VERTEX = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_RENDER_MODE  = 3'd0,
    REG_ORIGIN_XY    = 3'd1,
    REG_AXIS_GAINS   = 3'd2,
    REG_ADVANCE_PAD  = 3'd3,
    REG_SHEAR_COEFS  = 3'd4,
    REG_GLYPH_ROT    = 3'd5,
    REG_STRING_ROT   = 3'd6,
    REG_NONE         = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_START, OP_HDR, OP_LIFT, OP_DECODE, OP_SUB, OP_SHX,
    OP_SHY, OP_GPRE, OP_ROTA, OP_ROTB, OP_GPOST, OP_ADD, OP_SAVE, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SUB, S_SHX, S_SHY, S_GPRE, S_GRA, S_GRB, S_GPOST,
    S_SRA, S_SRB, S_ADD, S_SAVE, S_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic rot_string;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       lift;
    logic       new_path;
    logic [3:0] mode;
    logic       out_free;
  } dp_status_t;

  localparam int         CFG_WIDTH   = 48;
  localparam int         CODE_BIAS   = 82;
  localparam logic [7:0] LIFT_A      = 8'h20;
  localparam logic [7:0] LIFT_B      = 8'h52;
  localparam int         MIN_PAD     = 256;
  localparam int         SHEAR_ONE   = 256;
  localparam int         CFG_IDX_W   = 3;

endpackage

/* hw/rtl/hst_ctrl.sv */
// Controller: sequences load, decode, transform and emit steps
module hst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hst_pkg::dp_status_t status,
  output hst_pkg::dp_cmd_t    cmd
);

  hst_pkg::state_t state, state_next;
  logic second, second_next;
  logic any;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hst_pkg::S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    any            = status.mode != 4'd0;
    state_next     = state;
    second_next    = second;
    in_ready       = 1'b0;
    cmd.op         = hst_pkg::OP_NOP;
    cmd.rot_string = 1'b0;
    unique case (state)
      hst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = hst_pkg::OP_LOAD;
          state_next = hst_pkg::S_EXEC;
        end
      end
      hst_pkg::S_EXEC: begin
        state_next = hst_pkg::S_IDLE;
        unique case (status.cmd)
          hst_pkg::CMD_START:  cmd.op = hst_pkg::OP_START;
          hst_pkg::CMD_HEADER: cmd.op = hst_pkg::OP_HDR;
          hst_pkg::CMD_VERTEX: begin
            if (status.lift) begin
              cmd.op = hst_pkg::OP_LIFT;
            end else begin
              cmd.op = hst_pkg::OP_DECODE;
              if (!status.new_path) begin
                state_next  = hst_pkg::S_SUB;
                second_next = 1'b0;
              end
            end
          end
          default: cmd.op = hst_pkg::OP_NOP;
        endcase
      end
      hst_pkg::S_SUB: begin
        if (any) cmd.op = hst_pkg::OP_SUB;
        state_next = hst_pkg::S_SHX;
      end
      hst_pkg::S_SHX: begin
        if (status.mode[0]) cmd.op = hst_pkg::OP_SHX;
        state_next = hst_pkg::S_SHY;
      end
      hst_pkg::S_SHY: begin
        if (status.mode[1]) cmd.op = hst_pkg::OP_SHY;
        state_next = hst_pkg::S_GPRE;
      end
      hst_pkg::S_GPRE: begin
        if (status.mode[2]) cmd.op = hst_pkg::OP_GPRE;
        state_next = hst_pkg::S_GRA;
      end
      hst_pkg::S_GRA: begin
        if (status.mode[2]) cmd.op = hst_pkg::OP_ROTA;
        state_next = hst_pkg::S_GRB;
      end
      hst_pkg::S_GRB: begin
        if (status.mode[2]) cmd.op = hst_pkg::OP_ROTB;
        state_next = hst_pkg::S_GPOST;
      end
      hst_pkg::S_GPOST: begin
        if (status.mode[2]) cmd.op = hst_pkg::OP_GPOST;
        state_next = hst_pkg::S_SRA;
      end
      hst_pkg::S_SRA: begin
        cmd.rot_string = 1'b1;
        if (status.mode[3]) cmd.op = hst_pkg::OP_ROTA;
        state_next = hst_pkg::S_SRB;
      end
      hst_pkg::S_SRB: begin
        cmd.rot_string = 1'b1;
        if (status.mode[3]) cmd.op = hst_pkg::OP_ROTB;
        state_next = hst_pkg::S_ADD;
      end
      hst_pkg::S_ADD: begin
        if (any) cmd.op = hst_pkg::OP_ADD;
        state_next = second ? hst_pkg::S_EMIT : hst_pkg::S_SAVE;
      end
      hst_pkg::S_SAVE: begin
        cmd.op      = hst_pkg::OP_SAVE;
        second_next = 1'b1;
        state_next  = hst_pkg::S_SUB;
      end
      hst_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = hst_pkg::OP_EMIT;
          state_next = hst_pkg::S_IDLE;
        end
      end
      default: state_next = hst_pkg::S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/hst_dp.sv */
// Datapath: configuration, pen state, shared multiply-add and output register
module hst_dp #(
  parameter int COORD_WIDTH    = 21,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [hst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hst_pkg::CFG_WIDTH-1:0]         cfg_data,
  input  logic [17:0]                           in_data,
  input  hst_pkg::dp_cmd_t                      cmd,
  output hst_pkg::dp_status_t                   status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [4*COORD_WIDTH-1:0]              out_data
);

  localparam int CW = COORD_WIDTH;
  localparam int WW = COORD_WIDTH + 19;
  localparam int F  = COEF_FRAC_BITS;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [WW-1:0] wide_t;

  function automatic coord_t sat(input wide_t v);
    if (&v[WW-1:CW-1] || ~|v[WW-1:CW-1]) return v[CW-1:0];
    return v[WW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  logic [3:0]  render_mode;
  logic [41:0] origin_xy;
  logic [31:0] axis_gains;
  logic [19:0] advance_pad;
  logic [47:0] shear_coefs;
  logic [31:0] glyph_rotation;
  logic [31:0] string_rotation;

  logic [1:0] cmd_r;
  logic [7:0] byte_a, byte_b;
  coord_t pen_x, pen_y, pending_advance, last_x, last_y;
  coord_t cur_x, cur_y, wx, wy, sx, sy, tmp;
  logic   new_path;

  coord_t ox, oy, lm, rm, dec_x, dec_y, mac_a_c;
  logic signed [8:0]  a_s, b_s;
  logic signed [15:0] gx, gy;
  logic signed [16:0] ag, c1, c2, rc, rs;
  logic [19:0] pad;
  coord_t p, q;
  wide_t  mac_r, mac_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      render_mode     <= '0;
      origin_xy       <= '0;
      axis_gains      <= 32'h0100_0100;
      advance_pad     <= 20'd1024;
      shear_coefs     <= 48'd4096;
      glyph_rotation  <= 32'd4096;
      string_rotation <= 32'd4096;
    end else if (cfg_we) begin
      unique case (hst_pkg::reg_index_t'(cfg_index))
        hst_pkg::REG_RENDER_MODE: render_mode     <= cfg_data[3:0];
        hst_pkg::REG_ORIGIN_XY:   origin_xy       <= cfg_data[41:0];
        hst_pkg::REG_AXIS_GAINS:  axis_gains      <= cfg_data[31:0];
        hst_pkg::REG_ADVANCE_PAD: advance_pad     <= cfg_data[19:0];
        hst_pkg::REG_SHEAR_COEFS: shear_coefs     <= cfg_data[47:0];
        hst_pkg::REG_GLYPH_ROT:   glyph_rotation  <= cfg_data[31:0];
        hst_pkg::REG_STRING_ROT:  string_rotation <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ox  = sat(WW'($signed(origin_xy[20:0])));
    oy  = sat(WW'($signed(origin_xy[41:21])));
    gx  = $signed(axis_gains[15:0]);
    gy  = $signed(axis_gains[31:16]);
    a_s = $signed({1'b0, byte_a}) - 9'(hst_pkg::CODE_BIAS);
    b_s = $signed({1'b0, byte_b}) - 9'(hst_pkg::CODE_BIAS);
    ag  = gx[15] ? -17'(gx) : 17'(gx);
    lm  = sat(WW'(a_s) * WW'(ag));
    rm  = sat(WW'(b_s) * WW'(ag));
    pad = (advance_pad < 20'(hst_pkg::MIN_PAD)) ? 20'(hst_pkg::MIN_PAD) : advance_pad;
    dec_x = sat(WW'(pen_x) + WW'(sat(WW'(a_s) * WW'(gx))));
    dec_y = sat(WW'(pen_y) + WW'(sat(WW'(b_s) * WW'(gy))));
    rc = cmd.rot_string ? 17'($signed(string_rotation[15:0]))
                        : 17'($signed(glyph_rotation[15:0]));
    rs = cmd.rot_string ? 17'($signed(string_rotation[31:16]))
                        : 17'($signed(glyph_rotation[31:16]));
    p  = wx;
    q  = wy;
    c1 = '0;
    c2 = '0;
    unique case (cmd.op)
      hst_pkg::OP_SHX: begin
        p  = wy;
        c1 = 17'($signed(shear_coefs[15:0]));
      end
      hst_pkg::OP_SHY: begin
        c1 = 17'($signed(shear_coefs[31:16]));
        c2 = 17'($signed(shear_coefs[47:32]));
      end
      hst_pkg::OP_ROTA: begin
        c1 = rc;
        c2 = -rs;
      end
      hst_pkg::OP_ROTB: begin
        c1 = rs;
        c2 = rc;
      end
      default: ;
    endcase
    mac_sum = WW'(p) * WW'(c1) + WW'(q) * WW'(c2) + (WW'(1) <<< (F - 1));
    mac_r   = mac_sum >>> F;
    mac_a_c = sat(mac_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == hst_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      new_path        <= 1'b1;
      pen_x           <= '0;
      pen_y           <= '0;
      pending_advance <= '0;
      last_x          <= '0;
      last_y          <= '0;
    end else begin
      unique case (cmd.op)
        hst_pkg::OP_LOAD: begin
          cmd_r  <= in_data[1:0];
          byte_a <= in_data[9:2];
          byte_b <= in_data[17:10];
        end
        hst_pkg::OP_START: begin
          pen_x           <= ox;
          pen_y           <= oy;
          pending_advance <= '0;
          new_path        <= 1'b1;
          last_x          <= '0;
          last_y          <= '0;
        end
        hst_pkg::OP_HDR: begin
          pen_x           <= sat(WW'(pen_x) + WW'(pending_advance) - WW'(lm));
          pending_advance <= sat(WW'(rm) + WW'(pad));
          new_path        <= 1'b1;
        end
        hst_pkg::OP_LIFT: new_path <= 1'b1;
        hst_pkg::OP_DECODE: begin
          last_x <= dec_x;
          last_y <= dec_y;
          if (new_path) begin
            new_path <= 1'b0;
          end else begin
            wx    <= last_x;
            wy    <= last_y;
            cur_x <= dec_x;
            cur_y <= dec_y;
          end
        end
        hst_pkg::OP_SUB: begin
          wx <= sat(WW'(wx) - WW'(ox));
          wy <= sat(WW'(wy) - WW'(oy));
        end
        hst_pkg::OP_SHX:  wx <= sat(WW'(wx) + mac_r);
        hst_pkg::OP_SHY:  wy <= sat(mac_r + WW'(hst_pkg::SHEAR_ONE));
        hst_pkg::OP_GPRE: begin
          wx <= sat(WW'(wx) + WW'(ox) - WW'(pen_x));
          wy <= sat(WW'(wy) + WW'(oy) - WW'(pen_y));
        end
        hst_pkg::OP_ROTA: tmp <= mac_a_c;
        hst_pkg::OP_ROTB: begin
          wx <= tmp;
          wy <= mac_a_c;
        end
        hst_pkg::OP_GPOST: begin
          wx <= sat(WW'(wx) + WW'(pen_x) - WW'(ox));
          wy <= sat(WW'(wy) + WW'(pen_y) - WW'(oy));
        end
        hst_pkg::OP_ADD: begin
          wx <= sat(WW'(wx) + WW'(ox));
          wy <= sat(WW'(wy) + WW'(oy));
        end
        hst_pkg::OP_SAVE: begin
          sx <= wx;
          sy <= wy;
          wx <= cur_x;
          wy <= cur_y;
        end
        hst_pkg::OP_EMIT: out_data <= {wy, wx, sy, sx};
        default: ;
      endcase
    end
  end

  always_comb begin
    status.cmd      = cmd_r;
    status.lift     = (byte_a == hst_pkg::LIFT_A) && (byte_b == hst_pkg::LIFT_B);
    status.new_path = new_path;
    status.mode     = render_mode;
    status.out_free = !out_valid || out_ready;
  end

endmodule

/* hw/rtl/hershey_stroke_transform.sv */
// Top level: stroke transform from glyph byte stream to line segments
// Input beats on s_axis carry a command and two code bytes: string start,
// glyph header (left and right margin codes) or vertex pair (x, y codes).
// Output beats on m_axis carry one line segment each, four signed
// coordinates in fixed point. Configuration is a plain write port; the user
// must write it only while the block is idle, the block does not enforce it.
// One item is taken at a time. String start, glyph header, pen lift and the
// first vertex of a path give no segment. For any later vertex two points pass
// through ten steps each of the controller, with one shared two-product
// multiply-add unit doing the shear and rotation work, to make its segment.
// The segment waits in an output register; while it is not taken the next
// item is still accepted and processed up to the point of its own result.
// Reset restores the configuration registers to their defaults, puts the pen at
// zero and starts a new path; no beat is presented until a segment is ready.
module hershey_stroke_transform #(
  parameter int COORD_WIDTH    = 21,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,  // cmd, byte_a, byte_b
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,  // start_x, start_y, end_x, end_y
  input  logic                                cfg_we,
  input  logic [hst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hst_pkg::CFG_WIDTH-1:0]       cfg_data
);

  localparam int OUT_W = ((4*COORD_WIDTH+7)/8)*8;

  hst_pkg::dp_cmd_t    cmd;
  hst_pkg::dp_status_t status;
  logic [4*COORD_WIDTH-1:0] seg;

  hst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hst_dp #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata[17:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (seg)
  );

  assign m_tdata = OUT_W'(seg);

endmodule

/* hw/rtl/hst_checker.sv */
// Checker: port-level assertions on the stroke transform, bound to the top
`include "hershey_stroke_transform_assert.svh"

module hst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  logic accept, short_item;

  assign accept     = s_tvalid && s_tready;
  assign short_item = accept && (s_tdata[1:0] != hst_pkg::CMD_VERTEX);

  `HST_ASSERT_ALWAYS(a_reset_clears_out, clk, rst, !m_tvalid)
  `HST_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !s_tready)
  `HST_ASSERT_NEXT(a_short_item_returns, clk, rst, short_item, ##1 s_tready)
  `HST_ASSERT_NEXT(a_out_held, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `HST_ASSERT_SAME(a_busy_no_accept, clk, rst, !s_tready, !accept)

endmodule

bind hershey_stroke_transform hst_checker u_hst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
